>>> hdl/hrfp_pkg.sv
// Shared types, constants and helpers for the H.264 RTP FU-A packetizer.
// No dependencies.
package hrfp_pkg;

	localparam int LENGTH_BITS_DEF = 20;
	localparam int MIN_UNIT = 4;

	localparam logic [4:0] FU_A_TYPE = 5'd28;
	localparam logic [7:0] RTP_V2_BYTE = 8'h80;

	localparam logic [31:0] SSRC_RST = 32'd0;
	localparam logic [6:0] PT_RST = 7'd96;
	localparam logic [11:0] MAX_FRAG_RST = 12'd1400;

	typedef enum logic [1:0] {
		CFG_SSRC = 2'd0,
		CFG_PTYPE = 2'd1,
		CFG_MAX_FRAG = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_START = 4'b0010,
		PH_NALHDR = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	// burst kinds: error byte, bare payload byte, header+byte, header+FU bytes+byte
	typedef enum logic [2:0] {
		K_NONE = 3'd0,
		K_ERR = 3'd1,
		K_DATA = 3'd2,
		K_HDR = 3'd3,
		K_FU = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		logic last;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [7:0] fu_ind;
		logic [7:0] fu_hdr;
	} desc_t;

	function automatic logic [3:0] burst_len(input kind_t k);
		logic [3:0] n;
		n = 4'd0;
		case (k)
			K_ERR: n = 4'd1;
			K_DATA: n = 4'd1;
			K_HDR: n = 4'd13;
			K_FU: n = 4'd15;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

>>> hdl/h264_rtp_fu_a_packetizer.sv
// Top level of the H.264 RTP FU-A packetizer: config registers, parser, serializer.
// Depends on hrfp_pkg, hrfp_ctrl, hrfp_emit.
//
// Takes one NAL unit byte per transfer (start code included; length and
// timestamp sampled with first_byte) and emits RTP packet bytes one per
// transfer, packet_end on the last byte of each packet. A payload byte is a
// one-byte burst, so payload streams at one byte per clock while out_ready
// stays high. A byte that opens a packet is preceded by its 12-byte RTP
// header, so it ties up the serializer for a 13-byte burst (single packet)
// or a 15-byte burst (FU-A fragment: header, FU indicator, FU header, byte);
// input is held off while that burst drains through the single descriptor
// slot. Start-code and header-only bytes give no output. Config writes are
// taken in any cycle, but are only meant to happen while the block is idle.
module h264_rtp_fu_a_packetizer import hrfp_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic first_byte,
	input logic [19:0] unit_length,
	input logic [31:0] timestamp,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic packet_end,
	output logic bad_start_code,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic [31:0] ssrc_q;
	logic [6:0] pt_q;
	logic [11:0] max_frag_q;
	desc_t desc;
	logic desc_load, desc_free, in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready = desc_free;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q <= SSRC_RST;
			pt_q <= PT_RST;
			max_frag_q <= MAX_FRAG_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SSRC: ssrc_q <= cfg_data;
				CFG_PTYPE: pt_q <= cfg_data[6:0];
				CFG_MAX_FRAG: max_frag_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	hrfp_ctrl #(.LENGTH_BITS(LENGTH_BITS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.unit_length(unit_length),
		.timestamp(timestamp),
		.max_frag(max_frag_q),
		.desc(desc),
		.desc_load(desc_load)
	);

	hrfp_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.desc(desc),
		.desc_load(desc_load),
		.desc_free(desc_free),
		.ssrc(ssrc_q),
		.ptype(pt_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.packet_end(packet_end),
		.bad_start_code(bad_start_code)
	);

endmodule

>>> hdl/hrfp_ctrl.sv
// Per-byte unit parser: start code check, fragmentation decisions, sequence count.
// Produces at most one burst descriptor per transfer. Depends on hrfp_pkg.
module hrfp_ctrl import hrfp_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [7:0] data_byte,
	input logic first_byte,
	input logic [19:0] unit_length,
	input logic [31:0] timestamp,
	input logic [11:0] max_frag,
	output desc_t desc,
	output logic desc_load
);

	localparam int LB = LENGTH_BITS;

	logic [15:0] seq_q, seq_n;
	phase_t phase_q, phase_n;
	logic [LB-1:0] rem_q, rem_n;
	logic [11:0] fpos_q, fpos_n;
	logic [7:0] nal_q, nal_n;
	logic [31:0] ts_q, ts_n;
	logic [2:0] sc_q, sc_n;
	logic frag_q, frag_n;
	logic ffrag_q, ffrag_n;

	logic [LB-1:0] len, r, r1;
	logic [11:0] f;
	logic [2:0] k;
	logic rej, done, lastf, endf, big;
	phase_t ph;

	always_comb begin
		seq_n = seq_q;
		phase_n = phase_q;
		rem_n = rem_q;
		fpos_n = fpos_q;
		nal_n = nal_q;
		ts_n = ts_q;
		sc_n = sc_q;
		frag_n = frag_q;
		ffrag_n = ffrag_q;
		desc.kind = K_NONE;
		desc.data = data_byte;
		desc.last = 1'b0;
		desc.seq = seq_q;
		desc.ts = ts_q;
		desc.fu_ind = {nal_q[7:5], FU_A_TYPE};
		desc.fu_hdr = 8'd0;
		len = LB'(unit_length);
		f = (max_frag == 12'd0) ? 12'd1 : max_frag;
		ph = phase_q;
		r = rem_q;
		r1 = '0;
		k = sc_q;
		rej = 1'b0;
		done = 1'b0;
		lastf = 1'b0;
		endf = 1'b0;
		big = 1'b0;
		if (first_byte) begin
			ts_n = timestamp;
			desc.ts = timestamp;
			ffrag_n = 1'b1;
			frag_n = 1'b0;
			fpos_n = '0;
			sc_n = '0;
			k = '0;
			ph = PH_START;
			r = len;
			if (len < LB'(MIN_UNIT)) begin
				rej = 1'b1;
			end else begin
				rem_n = len;
				phase_n = PH_START;
			end
		end
		if (!rej) begin
			if (ph == PH_IDLE || r == '0) begin
				phase_n = PH_IDLE;
			end else begin
				r1 = r - LB'(1);
				rem_n = r1;
				case (ph)
					PH_START: begin
						if (k < 3'd2) begin
							if (data_byte != 8'd0) rej = 1'b1;
							else sc_n = k + 3'd1;
						end else if (k == 3'd2) begin
							if (data_byte == 8'd1) begin
								sc_n = 3'd3;
								done = 1'b1;
							end else if (data_byte == 8'd0) begin
								sc_n = 3'd3;
							end else begin
								rej = 1'b1;
							end
						end else begin
							if (data_byte != 8'd1) rej = 1'b1;
							else begin
								sc_n = 3'd4;
								done = 1'b1;
							end
						end
						if (done) begin
							if (r1 == '0) rej = 1'b1;
							else phase_n = PH_NALHDR;
						end
					end
					PH_NALHDR: begin
						nal_n = data_byte;
						big = ({1'b0, r1} + (LB+1)'(1)) > (LB+1)'(f);
						if (big) begin
							frag_n = 1'b1;
						end else begin
							desc.kind = K_HDR;
							desc.last = (r1 == '0);
						end
						phase_n = PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (frag_q) begin
							endf = (({1'b0, fpos_q} + 13'd1) >= {1'b0, f}) || (r1 == '0);
							desc.last = endf;
							if (fpos_q == 12'd0) begin
								lastf = (({1'b0, r1} + (LB+1)'(1)) <= (LB+1)'(f)) && !ffrag_q;
								desc.kind = K_FU;
								desc.fu_hdr = {ffrag_q, lastf, 1'b0, nal_q[4:0]};
							end else begin
								desc.kind = K_DATA;
							end
							if (endf) begin
								fpos_n = '0;
								ffrag_n = 1'b0;
							end else begin
								fpos_n = fpos_q + 12'd1;
							end
						end else begin
							desc.kind = K_DATA;
							desc.last = (r1 == '0);
						end
					end
					default: phase_n = PH_IDLE;
				endcase
				if (!rej && r1 == '0) phase_n = PH_IDLE;
			end
		end
		if (rej) begin
			phase_n = PH_IDLE;
			rem_n = '0;
			desc.kind = K_ERR;
			desc.data = 8'd0;
			desc.last = 1'b1;
		end
		if (desc.kind == K_HDR || desc.kind == K_FU) seq_n = seq_q + 16'd1;
	end

	assign desc_load = in_fire && (desc.kind != K_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			phase_q <= PH_IDLE;
			rem_q <= '0;
			fpos_q <= '0;
			nal_q <= '0;
			ts_q <= '0;
			sc_q <= '0;
			frag_q <= 1'b0;
			ffrag_q <= 1'b1;
		end else if (in_fire) begin
			seq_q <= seq_n;
			phase_q <= phase_n;
			rem_q <= rem_n;
			fpos_q <= fpos_n;
			nal_q <= nal_n;
			ts_q <= ts_n;
			sc_q <= sc_n;
			frag_q <= frag_n;
			ffrag_q <= ffrag_n;
		end
	end

endmodule

>>> hdl/hrfp_emit.sv
// Burst serializer: holds one descriptor and walks its bytes into the output register.
// Depends on hrfp_pkg.
module hrfp_emit import hrfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input desc_t desc,
	input logic desc_load,
	output logic desc_free,
	input logic [31:0] ssrc,
	input logic [6:0] ptype,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic packet_end,
	output logic bad_start_code
);

	desc_t desc_q;
	logic busy_q;
	logic [3:0] idx_q;
	logic ov_q, end_q, bad_q;
	logic [7:0] byte_q;

	logic push, last;
	logic [7:0] sel;

	assign push = busy_q && (!ov_q || out_ready);
	assign last = (idx_q == burst_len(desc_q.kind) - 4'd1);
	assign desc_free = !busy_q || (push && last);

	always_comb begin
		sel = desc_q.data;
		if (desc_q.kind == K_HDR || desc_q.kind == K_FU) begin
			case (idx_q)
				4'd0: sel = RTP_V2_BYTE;
				4'd1: sel = {1'b0, ptype};
				4'd2: sel = desc_q.seq[15:8];
				4'd3: sel = desc_q.seq[7:0];
				4'd4: sel = desc_q.ts[31:24];
				4'd5: sel = desc_q.ts[23:16];
				4'd6: sel = desc_q.ts[15:8];
				4'd7: sel = desc_q.ts[7:0];
				4'd8: sel = ssrc[31:24];
				4'd9: sel = ssrc[23:16];
				4'd10: sel = ssrc[15:8];
				4'd11: sel = ssrc[7:0];
				4'd12: sel = (desc_q.kind == K_FU) ? desc_q.fu_ind : desc_q.data;
				4'd13: sel = desc_q.fu_hdr;
				default: sel = desc_q.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (desc_load) busy_q <= 1'b1;
			else if (push && last) busy_q <= 1'b0;
			if (push) idx_q <= last ? 4'd0 : idx_q + 4'd1;
			if (push) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_load) desc_q <= desc;
		if (push) begin
			byte_q <= sel;
			end_q <= last && desc_q.last;
			bad_q <= (desc_q.kind == K_ERR);
		end
	end

	assign out_valid = ov_q;
	assign out_byte = byte_q;
	assign packet_end = end_q;
	assign bad_start_code = bad_q;

`ifndef SYNTHESIS
	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < burst_len(desc_q.kind))
		else $error("burst index past end");
	a_bad_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && bad_q |-> end_q && byte_q == 8'd0)
		else $error("error result malformed");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		desc_load |-> desc_free)
		else $error("descriptor overwritten");
	a_new_burst_idx: assert property (@(posedge clk) disable iff (!arst_n)
		desc_load |=> idx_q == 4'd0)
		else $error("burst starts mid-count");
`endif

endmodule
